/* hw/rtl/hsl_to_rgb_converter_unit_macros.svh */
// Assertion macros for the HSL to RGB converter.
// Used by hsl_to_rgb_converter_unit; expects i_clk and i_rst_n in scope.
`ifndef HSL_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define HSL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define HSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hsl2rgb_pkg.sv */
// Shared types, hue constants and width helpers for the HSL to RGB converter.
// No dependencies.
package hsl2rgb_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int NSTG          = 5;
    localparam int RAMP_W        = 10;

    // hue angles in sixteenths of a degree
    localparam logic signed [14:0] HUE_FULL  = 15'sd5760;
    localparam logic signed [14:0] HUE_THIRD = 15'sd1920;
    localparam logic signed [14:0] HUE_60    = 15'sd960;
    localparam logic signed [14:0] HUE_180   = 15'sd2880;
    localparam logic signed [14:0] HUE_240   = 15'sd3840;

    typedef logic [RAMP_W-1:0] t_ramp;
    localparam t_ramp RAMP_MAX = 10'd960;

    typedef struct packed {
        logic [12:0] hue;
        logic [8:0]  lightness;
        logic [8:0]  saturation;
    } t_hsl;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

    // unsigned width of l*ONE, s*ONE and l*s
    function automatic int prod_width(input int frac);
        return (frac + 9 > 18) ? frac + 9 : 18;
    endfunction

    // signed width of m1 and m2-m1 (over ONE*ONE)
    function automatic int m_width(input int frac);
        return prod_width(frac) + 3;
    endfunction

endpackage

/* hw/rtl/hsl2rgb_front.sv */
// Front end, stages 1-2: hue ramp positions, l*s, then m1 and m2-m1, grey value.
// Depends on hsl2rgb_pkg.
module hsl2rgb_front #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  hsl2rgb_pkg::t_stage_en                       i_en,
    input  hsl2rgb_pkg::t_hsl                            i_data,
    output logic signed [hsl2rgb_pkg::m_width(FRAC_BITS)-1:0] o_m1,
    output logic signed [hsl2rgb_pkg::m_width(FRAC_BITS)-1:0] o_d,
    output hsl2rgb_pkg::t_ramp                           o_t [3],
    output logic                                         o_grey,
    output logic [7:0]                                   o_gval
);
    import hsl2rgb_pkg::*;

    localparam int WP = prod_width(FRAC_BITS);
    localparam int WM = m_width(FRAC_BITS);
    localparam logic [WP-1:0] HALF = WP'(1) << (FRAC_BITS - 1);

    // hue offset -> position on the ramp, 0..960
    function automatic t_ramp hue_ramp(input logic [12:0] hue, input logic signed [14:0] off);
        logic signed [14:0] h;
        logic signed [14:0] dn;
        t_ramp              r;
        h  = $signed({2'b00, hue}) + off;
        if (h > HUE_FULL) begin
            h = h - HUE_FULL;
        end else if (h < 15'sd0) begin
            h = h + HUE_FULL;
        end
        dn = HUE_240 - h;
        if (h < HUE_60) begin
            r = h[RAMP_W-1:0];
        end else if (h < HUE_180) begin
            r = RAMP_MAX;
        end else if (h < HUE_240) begin
            r = dn[RAMP_W-1:0];
        end else begin
            r = '0;
        end
        return r;
    endfunction

    // stage 1
    logic [8:0]  r_l, r_s;
    logic [17:0] r_ls;
    logic        r_lo, r_grey1;
    t_ramp       r_t1 [3];

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_l     <= i_data.lightness;
            r_s     <= i_data.saturation;
            r_ls    <= 18'(i_data.lightness) * 18'(i_data.saturation);
            r_lo    <= WP'(i_data.lightness) <= HALF;
            r_grey1 <= i_data.saturation == '0;
            r_t1[0] <= hue_ramp(i_data.hue, HUE_THIRD);
            r_t1[1] <= hue_ramp(i_data.hue, 15'sd0);
            r_t1[2] <= hue_ramp(i_data.hue, -HUE_THIRD);
        end
    end

    // stage 2
    logic [WP-1:0]        lone_u, sone_u;
    logic signed [WM-1:0] lone_s, sone_s, ls_s, n_m1, n_d;
    logic [16:0]          gmul, gsh;
    logic [7:0]           n_gval;

    always_comb begin
        lone_u = WP'(r_l) << FRAC_BITS;
        sone_u = WP'(r_s) << FRAC_BITS;
        lone_s = $signed({3'b000, lone_u});
        sone_s = $signed({3'b000, sone_u});
        ls_s   = $signed({3'b000, WP'(r_ls)});
        if (r_lo) begin
            n_m1 = lone_s - ls_s;
            n_d  = ls_s <<< 1;
        end else begin
            n_m1 = lone_s - sone_s + ls_s;
            n_d  = (sone_s - ls_s) <<< 1;
        end
        // grey: l*255 >> FRAC_BITS, saturated
        gmul   = {r_l, 8'b0} - {8'b0, r_l};
        gsh    = gmul >> FRAC_BITS;
        n_gval = (|gsh[16:8]) ? 8'hFF : gsh[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            o_m1   <= n_m1;
            o_d    <= n_d;
            o_t    <= r_t1;
            o_grey <= r_grey1;
            o_gval <= n_gval;
        end
    end

endmodule

/* hw/rtl/hsl2rgb_chan.sv */
// One color channel, stages 3-5: ramp multiply, sum, scale by 255/960 and clamp.
// Depends on hsl2rgb_pkg.
module hsl2rgb_chan #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                                              i_clk,
    input  hsl2rgb_pkg::t_stage_en                            i_en,
    input  logic signed [hsl2rgb_pkg::m_width(FRAC_BITS)-1:0] i_m1,
    input  logic signed [hsl2rgb_pkg::m_width(FRAC_BITS)-1:0] i_d,
    input  hsl2rgb_pkg::t_ramp                                i_t,
    input  logic                                              i_grey,
    input  logic [7:0]                                        i_gval,
    output logic [7:0]                                        o_val
);
    import hsl2rgb_pkg::*;

    localparam int WM = m_width(FRAC_BITS);
    localparam int WN = WM + 12;
    // 255/960 == 17/64, so value = num*17 >> (6 + 2*FRAC_BITS)
    localparam int SH = 6 + 2 * FRAC_BITS;
    localparam int WV = (WN + 5 > SH + 9) ? WN + 5 : SH + 9;

    // stage 3
    logic signed [WM+10:0] r_p;
    logic signed [WM+9:0]  r_m1k, m1x;
    logic                  r_grey3, r_grey4;
    logic [7:0]            r_gval3, r_gval4;

    assign m1x = {{10{i_m1[WM-1]}}, i_m1};

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_p     <= i_d * $signed({1'b0, i_t});
            r_m1k   <= (m1x <<< 10) - (m1x <<< 6);
            r_grey3 <= i_grey;
            r_gval3 <= i_gval;
        end
    end

    // stage 4
    logic signed [WN-1:0] r_num;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_num   <= {{1{r_p[WM+10]}}, r_p} + {{2{r_m1k[WM+9]}}, r_m1k};
            r_grey4 <= r_grey3;
            r_gval4 <= r_gval3;
        end
    end

    // stage 5
    logic signed [WV-1:0] nx, v, q;
    logic [7:0]           n_val;

    always_comb begin
        nx = {{(WV-WN){r_num[WN-1]}}, r_num};
        v  = (nx <<< 4) + nx;
        q  = v >>> SH;
        if (r_grey4) begin
            n_val = r_gval4;
        end else if (r_num[WN-1] || (r_num == '0)) begin
            n_val = '0;
        end else if (|q[WV-1:8]) begin
            n_val = 8'hFF;
        end else begin
            n_val = q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            o_val <= n_val;
        end
    end

endmodule

/* hw/rtl/hsl_to_rgb_converter_unit.sv */
// HSL to RGB converter: takes one pixel per clock while o_stall is low and returns 8-bit red,
// green and blue through the five-stage datapath. Each stage holds one pixel, so the sustained
// rate is one beat per cycle while i_stall is low; the output stage's stall reaches o_stall
// through the per-stage ready chain, and empty stages fill even while the output is stalled.
// Depends on hsl2rgb_pkg, hsl2rgb_front, hsl2rgb_chan and the assertion macro header.
`include "hsl_to_rgb_converter_unit_macros.svh"

module hsl_to_rgb_converter_unit #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  hsl2rgb_pkg::t_hsl i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output hsl2rgb_pkg::t_rgb o_data
);
    import hsl2rgb_pkg::*;

    localparam int WM = m_width(FRAC_BITS);

    logic [NSTG-1:0] r_vld, n_vld, rdy;
    t_stage_en       en;
    logic            in_acc, out_acc;

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld[0] = rdy[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign en.s1   = rdy[0];
    assign en.s2   = rdy[1];
    assign en.s3   = rdy[2];
    assign en.s4   = rdy[3];
    assign en.s5   = rdy[4];
    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NSTG-1];
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    logic signed [WM-1:0] m1, d;
    t_ramp                t [3];
    logic                 grey;
    logic [7:0]           gval;
    logic [7:0]           val [3];

    hsl2rgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (i_data),
        .o_m1   (m1),
        .o_d    (d),
        .o_t    (t),
        .o_grey (grey),
        .o_gval (gval)
    );

    for (genvar g = 0; g < 3; g++) begin : g_chan
        hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_m1   (m1),
            .i_d    (d),
            .i_t    (t[g]),
            .i_grey (grey),
            .i_gval (gval),
            .o_val  (val[g])
        );
    end

    assign o_data.red   = val[0];
    assign o_data.green = val[1];
    assign o_data.blue  = val[2];

    `HSL_ASSERT_IMPL(a_full_no_accept, in_acc, !((&r_vld) && i_stall), "beat taken into a full, stalled pipeline")
    `HSL_ASSERT_IMPL(a_empty_out_ready, !r_vld[NSTG-1], !o_stall, "stall raised with empty output stage")
    `HSL_ASSERT_NEXT(a_vld_count, i_rst_n, $countones(r_vld) == $past($countones(r_vld)) + 32'($past(in_acc)) - 32'($past(out_acc)), "beats in flight do not match accepted minus delivered")

endmodule
